// File: rtl/core/msp_pkg.sv
// Shared constants and control types for the MSP v1 frame parser.
// Used by msp_res_if, the controller, the datapath and the top level.
// No dependencies.
package msp_pkg;

    // Payload buffer depth and the address width that follows from it.
    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);

    // Fixed field widths of the result item.
    localparam int LEN_W   = 7;
    localparam int INDEX_W = 6;

    // Header and direction characters.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;

    // Packet kind codes.
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic set_kind;
        logic load_size;
        logic load_command;
        logic store_byte;
        logic emit_status;
        logic status_consumed;
        logic emit_empty;
        logic start_drain;
        logic read_byte;
        logic load_data;
        logic advance;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dollar;
        logic is_m;
        logic is_arrow;
        logic size_ok;
        logic body_more;
        logic xor_match;
        logic zero_len;
        logic drain_last;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/msp_rx_if.sv
// Receive byte channel of the MSP v1 frame parser.
// Carries one serial byte per transfer; no dependencies.
interface msp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/msp_res_if.sv
// Result channel of the MSP v1 frame parser.
// Field widths come from msp_pkg.
interface msp_res_if;
    logic                        valid;
    logic                        ready;
    logic                        consumed;
    logic                        frame_valid;
    logic                        packet_kind;
    logic [7:0]                  command_code;
    logic [msp_pkg::LEN_W-1:0]   payload_length;
    logic                        payload_valid;
    logic [7:0]                  data_byte;
    logic [msp_pkg::INDEX_W-1:0] byte_index;
    logic                        last;

    modport source (
        output valid, output consumed, output frame_valid, output packet_kind,
        output command_code, output payload_length, output payload_valid,
        output data_byte, output byte_index, output last, input ready
    );
    modport sink (
        input valid, input consumed, input frame_valid, input packet_kind,
        input command_code, input payload_length, input payload_valid,
        input data_byte, input byte_index, input last, output ready
    );
endinterface

// File: rtl/core/msp_v1_frame_parser.sv
// Top level of the MSP v1 receive frame parser.
// Instantiates msp_controller and msp_datapath; uses msp_pkg, msp_rx_if, msp_res_if.
//
// Usage: serial bytes enter on the rx channel, one byte per transfer. Results
// leave on the res channel. Every byte gives one status result (consumed is
// low only for a byte other than '$' seen while idle), except the checksum
// byte of a good frame, which gives the frame's payload as a run of results
// with last on the final byte, or a single empty result for a zero-length
// frame. A bad checksum gives only a status result.
//
// Latency and throughput: a status result is in the output register in the
// cycle after its byte's transfer, and the next byte is taken in that same
// cycle if the result is taken or the register is empty, so bytes flow at
// one per cycle. A good frame drains one payload byte at a time: each
// payload byte is read from the buffer memory and then loaded into the
// output register; rx ready is low during the drain.
// Reset returns the parser to idle with an empty output register; the payload
// buffer needs no clearing since only bytes of the current frame are read.
// When the receiver stalls, the pending result holds and rx ready drops.
module msp_v1_frame_parser (
    input  logic      clk,
    input  logic      rst_n,
    msp_rx_if.sink    rx,
    msp_res_if.source res
);

    // Command and status between the controller and the datapath.
    msp_pkg::cmd_t cmd;
    msp_pkg::sts_t sts;

    // The controller owns the handshake on the byte side and sequences the
    // payload drain; the datapath owns the output register.
    msp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msp_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .sts     (sts),
        .res     (res)
    );

endmodule

// File: rtl/core/msp_datapath.sv
// Datapath of the MSP v1 frame parser: frame registers, checksum, payload
// buffer and the result output register. Depends on msp_pkg and msp_res_if.
module msp_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        rx_byte,
    input  msp_pkg::cmd_t     cmd,
    output msp_pkg::sts_t     sts,
    msp_res_if.source         res
);

    logic                          kind_reg;
    logic [msp_pkg::LEN_W-1:0]     length_reg;
    logic [7:0]                    command_reg;
    logic [msp_pkg::LEN_W-1:0]     fill_reg;
    logic [7:0]                    xor_reg;
    logic [msp_pkg::ADDR_W-1:0]    rd_idx_reg;
    logic [7:0]                    mem_q_reg;
    logic [7:0]                    mem [msp_pkg::BUFFER_BYTES];

    logic                          out_valid_reg;
    logic                          consumed_reg;
    logic                          frame_valid_reg;
    logic                          kind_out_reg;
    logic [7:0]                    command_out_reg;
    logic [msp_pkg::LEN_W-1:0]     length_out_reg;
    logic                          payload_valid_reg;
    logic [7:0]                    data_reg;
    logic [msp_pkg::INDEX_W-1:0]   index_reg;
    logic                          last_reg;

    logic                          load_any;
    logic [msp_pkg::LEN_W-1:0]     rd_next_count;

    assign load_any      = cmd.emit_status | cmd.emit_empty | cmd.load_data;
    assign rd_next_count = msp_pkg::LEN_W'(rd_idx_reg) + msp_pkg::LEN_W'(1);

    always_comb
    begin
        sts.is_dollar  = (rx_byte == msp_pkg::CHAR_DOLLAR);
        sts.is_m       = (rx_byte == msp_pkg::CHAR_M);
        sts.is_arrow   = (rx_byte == msp_pkg::CHAR_LT) || (rx_byte == msp_pkg::CHAR_GT);
        sts.size_ok    = (rx_byte <= 8'(msp_pkg::BUFFER_BYTES));
        sts.body_more  = (fill_reg < length_reg);
        sts.xor_match  = (xor_reg == rx_byte);
        sts.zero_len   = (length_reg == '0);
        sts.drain_last = (rd_next_count == length_reg);
        sts.out_free   = !out_valid_reg || res.ready;
    end

    // Frame registers and checksum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= msp_pkg::KIND_COMMAND;
            length_reg  <= '0;
            command_reg <= '0;
            fill_reg    <= '0;
            xor_reg     <= '0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.set_kind)
            begin
                kind_reg <= (rx_byte == msp_pkg::CHAR_GT) ? msp_pkg::KIND_REPLY
                                                          : msp_pkg::KIND_COMMAND;
            end
            if (cmd.load_size)
            begin
                length_reg <= rx_byte[msp_pkg::LEN_W-1:0];
                fill_reg   <= '0;
                xor_reg    <= rx_byte;
            end
            if (cmd.load_command)
            begin
                command_reg <= rx_byte;
                xor_reg     <= xor_reg ^ rx_byte;
            end
            if (cmd.store_byte)
            begin
                xor_reg  <= xor_reg ^ rx_byte;
                fill_reg <= fill_reg + msp_pkg::LEN_W'(1);
            end
            if (cmd.start_drain)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                rd_idx_reg <= rd_idx_reg + msp_pkg::ADDR_W'(1);
            end
        end
    end

    // Payload buffer with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            mem[fill_reg[msp_pkg::ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.read_byte)
        begin
            mem_q_reg <= mem[rd_idx_reg];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_status)
        begin
            consumed_reg      <= cmd.status_consumed;
            frame_valid_reg   <= 1'b0;
            kind_out_reg      <= 1'b0;
            command_out_reg   <= '0;
            length_out_reg    <= '0;
            payload_valid_reg <= 1'b0;
            data_reg          <= '0;
            index_reg         <= '0;
            last_reg          <= 1'b1;
        end
        else if (cmd.emit_empty || cmd.load_data)
        begin
            consumed_reg      <= 1'b1;
            frame_valid_reg   <= 1'b1;
            kind_out_reg      <= kind_reg;
            command_out_reg   <= command_reg;
            length_out_reg    <= length_reg;
            payload_valid_reg <= cmd.load_data;
            data_reg          <= cmd.load_data ? mem_q_reg : 8'h00;
            index_reg         <= cmd.load_data ? msp_pkg::INDEX_W'(rd_idx_reg) : '0;
            last_reg          <= cmd.load_data ? sts.drain_last : 1'b1;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.consumed       = consumed_reg;
    assign res.frame_valid    = frame_valid_reg;
    assign res.packet_kind    = kind_out_reg;
    assign res.command_code   = command_out_reg;
    assign res.payload_length = length_out_reg;
    assign res.payload_valid  = payload_valid_reg;
    assign res.data_byte      = data_reg;
    assign res.byte_index     = index_reg;
    assign res.last           = last_reg;

endmodule

// File: rtl/core/msp_controller.sv
// Controller of the MSP v1 frame parser: header and body parse phases and
// the payload drain sequence. Depends on msp_pkg.
module msp_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rx_valid,
    output logic          rx_ready,
    input  msp_pkg::sts_t sts,
    output msp_pkg::cmd_t cmd
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_DOLLAR = 3'd1;
    localparam logic [2:0] PH_M      = 3'd2;
    localparam logic [2:0] PH_ARROW  = 3'd3;
    localparam logic [2:0] PH_SIZE   = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign rx_ready = (state_reg == ST_RUN) && sts.out_free;
    assign accept   = rx_valid && rx_ready;

    always_comb
    begin
        phase_next = phase_reg;
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    cmd.emit_status     = 1'b1;
                    cmd.status_consumed = 1'b1;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (sts.is_dollar)
                            begin
                                phase_next = PH_DOLLAR;
                            end
                            else
                            begin
                                cmd.status_consumed = 1'b0;
                            end
                        end
                        PH_DOLLAR:
                        begin
                            phase_next = sts.is_m ? PH_M : PH_IDLE;
                        end
                        PH_M:
                        begin
                            if (sts.is_arrow)
                            begin
                                cmd.set_kind = 1'b1;
                                phase_next   = PH_ARROW;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_ARROW:
                        begin
                            if (sts.size_ok)
                            begin
                                cmd.load_size = 1'b1;
                                phase_next    = PH_SIZE;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_SIZE:
                        begin
                            cmd.load_command = 1'b1;
                            phase_next       = PH_BODY;
                        end
                        PH_BODY:
                        begin
                            if (sts.body_more)
                            begin
                                cmd.store_byte = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                if (sts.xor_match)
                                begin
                                    cmd.emit_status = 1'b0;
                                    if (sts.zero_len)
                                    begin
                                        cmd.emit_empty = 1'b1;
                                    end
                                    else
                                    begin
                                        cmd.start_drain = 1'b1;
                                        state_next      = ST_READ;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.read_byte = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_data = 1'b1;
                    if (sts.drain_last)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            state_reg <= ST_RUN;
        end
        else
        begin
            phase_reg <= phase_next;
            state_reg <= state_next;
        end
    end

endmodule
